FILE: hdl/hoie_pkg.sv
// Shared constants, types and helper functions for the Ising energy unit.
`default_nettype none
package hoie_pkg;
  localparam int MAX_SPINS = 256;
  localparam int MAX_TERMS = 256;
  localparam int MAX_DEGREE = 4;
  localparam int SPIN_W = $clog2(MAX_SPINS);
  localparam int TERM_W = $clog2(MAX_TERMS);
  localparam int SLOT_W = $clog2(MAX_DEGREE);
  localparam int VAR_ADDR_W = TERM_W + SLOT_W;
  localparam int ACC_W = 48;
  localparam int COEF_W = 32;
  localparam int DEG_W = 3;

  localparam logic [3:0] OP_SET_SPIN = 4'd0;
  localparam logic [3:0] OP_SET_BIAS = 4'd1;
  localparam logic [3:0] OP_SET_COEFF = 4'd2;
  localparam logic [3:0] OP_SET_DEGREE = 4'd3;
  localparam logic [3:0] OP_SET_VAR = 4'd4;
  localparam logic [3:0] OP_ENERGY = 4'd5;
  localparam logic [3:0] OP_COUPLING = 4'd6;
  localparam logic [3:0] OP_FIELD = 4'd7;
  localparam logic [3:0] OP_DELTA = 4'd8;

  localparam logic [1:0] REG_OFFSET = 2'd0;
  localparam logic [1:0] REG_SPINS = 2'd1;
  localparam logic [1:0] REG_TERMS = 2'd2;

  typedef logic signed [ACC_W-1:0] acc_t;

  // Saturating add of a 49-bit widened sum back into 48 bits.
  function automatic acc_t sat_add(input acc_t a, input acc_t b);
    logic signed [ACC_W:0] s;
    begin
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1])
        sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      else
        sat_add = s[ACC_W-1:0];
    end
  endfunction

  // Saturated 2 * a, or -2 * a when negate is set, computed two bits wider.
  function automatic acc_t sat_double(input acc_t a, input logic negate);
    logic signed [ACC_W+1:0] d;
    begin
      d = {a[ACC_W-1], a, 1'b0};
      if (negate) d = -d;
      if (d[ACC_W+1:ACC_W-1] == 3'b000 || d[ACC_W+1:ACC_W-1] == 3'b111)
        sat_double = d[ACC_W-1:0];
      else
        sat_double = d[ACC_W+1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
  endfunction
endpackage
`default_nettype wire

FILE: hdl/hoie_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module hoie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/higher_order_ising_energy_unit_top.sv
// Top level of the higher-order Ising energy unit: stores, sequencer and result register.
//
// The unit keeps spins, per-spin biases and a table of higher-order terms in
// on-chip memories, and answers energy, coupling, local field and flip delta
// queries in signed Q32.16 with saturation on every accumulation. A write
// transaction (set spin, bias, coefficient, degree or variable) is completed
// in the cycle it is accepted and produces no result; the next transaction
// can follow in the very next cycle. Queries are served by a sequencer that
// reads the memories one entry per cycle. A used term takes the degree and
// coefficient read, then for every variable one variable-store read and one
// spin-store read; an unused term takes only the degree and coefficient read.
// A field or delta query with an index outside the model answers straight
// from the idle state, with a zero result and status set. After reset the
// unit sweeps all spin, bias, coefficient and degree entries to zero, one
// entry per cycle, while it accepts no input transaction (configuration
// writes are still taken). One item is processed at a time; the result
// register is freed as soon as the result transaction completes, and a new
// input is accepted only after that.
`default_nettype none
module higher_order_ising_energy_unit_top
  import hoie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  opcode,
  input  wire logic [7:0]  index,
  input  wire logic [1:0]  slot,
  input  wire logic [7:0]  variable,
  input  wire logic [2:0]  term_degree,
  input  wire logic signed [31:0] value,
  input  wire logic        spin_negative,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [47:0] result_value,
  output logic             status
);
  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_BIAS = 4'd2,
    S_TDEG = 4'd3, S_VAR = 4'd4, S_SPIN = 4'd5, S_TACC = 4'd6, S_DONE = 4'd7,
    S_OUT = 4'd8, S_FSPIN = 4'd9;

  logic signed [31:0] offset;
  logic [8:0] spins_in_use, terms_in_use;
  logic [3:0] state;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0; spins_in_use <= 9'd256; terms_in_use <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OFFSET: offset <= cfg_data;
        REG_SPINS: spins_in_use <= cfg_data[8:0];
        REG_TERMS: terms_in_use <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  logic [SPIN_W:0] eff_spins;
  logic [TERM_W:0] eff_terms;
  assign eff_spins = (spins_in_use > 9'(MAX_SPINS)) ? (SPIN_W+1)'(MAX_SPINS)
                                                     : (SPIN_W+1)'(spins_in_use);
  assign eff_terms = (terms_in_use > 9'(MAX_TERMS)) ? (TERM_W+1)'(MAX_TERMS)
                                                     : (TERM_W+1)'(terms_in_use);

  // Memory ports.
  logic spin_we, bias_we, coef_we, deg_we, var_we;
  logic [SPIN_W-1:0] spin_wa, spin_ra, bias_wa, bias_ra;
  logic [TERM_W-1:0] coef_wa, coef_ra, deg_wa, deg_ra;
  logic [VAR_ADDR_W-1:0] var_wa, var_ra;
  logic spin_wd, spin_rd;
  logic [31:0] bias_wd, bias_rd, coef_wd, coef_rd;
  logic [DEG_W-1:0] deg_wd, deg_rd;
  logic [7:0] var_rd;

  hoie_ram #(.WIDTH(1), .DEPTH(MAX_SPINS)) u_spin (.clk, .we(spin_we), .waddr(spin_wa),
    .wdata(spin_wd), .raddr(spin_ra), .rdata(spin_rd));
  hoie_ram #(.WIDTH(32), .DEPTH(MAX_SPINS)) u_bias (.clk, .we(bias_we), .waddr(bias_wa),
    .wdata(bias_wd), .raddr(bias_ra), .rdata(bias_rd));
  hoie_ram #(.WIDTH(32), .DEPTH(MAX_TERMS)) u_coef (.clk, .we(coef_we), .waddr(coef_wa),
    .wdata(coef_wd), .raddr(coef_ra), .rdata(coef_rd));
  hoie_ram #(.WIDTH(DEG_W), .DEPTH(MAX_TERMS)) u_deg (.clk, .we(deg_we), .waddr(deg_wa),
    .wdata(deg_wd), .raddr(deg_ra), .rdata(deg_rd));
  hoie_ram #(.WIDTH(8), .DEPTH(MAX_TERMS*MAX_DEGREE)) u_var (.clk, .we(var_we),
    .waddr(var_wa), .wdata(variable), .raddr(var_ra), .rdata(var_rd));

  // Captured transaction.
  logic [3:0] op;
  logic [7:0] qidx;
  logic [SPIN_W:0] clr_cnt;
  logic [SPIN_W:0] scnt;          // spin counter for the bias sweep
  logic [TERM_W:0] tcnt;          // term counter
  logic [SLOT_W:0] kcnt;          // variable slot counter
  logic [SLOT_W:0] len;
  logic [SLOT_W:0] hits;
  logic tneg, qneg, first;
  logic signed [31:0] coef_q;
  acc_t acc;

  assign in_ready = (state == S_IDLE) && !out_valid;

  // Write side: writes happen only on accept of a set transaction or during clear.
  always_comb begin
    logic acc_in;
    acc_in = in_valid && in_ready;
    spin_we = (state == S_CLEAR) || (acc_in && opcode == OP_SET_SPIN);
    bias_we = (state == S_CLEAR) || (acc_in && opcode == OP_SET_BIAS);
    coef_we = (state == S_CLEAR) || (acc_in && opcode == OP_SET_COEFF);
    deg_we  = (state == S_CLEAR) || (acc_in && opcode == OP_SET_DEGREE);
    var_we  = acc_in && opcode == OP_SET_VAR;
    spin_wa = (state == S_CLEAR) ? clr_cnt[SPIN_W-1:0] : SPIN_W'(index);
    bias_wa = spin_wa;
    coef_wa = (state == S_CLEAR) ? TERM_W'(clr_cnt) : TERM_W'(index);
    deg_wa = coef_wa;
    spin_wd = (state == S_CLEAR) ? 1'b0 : spin_negative;
    bias_wd = (state == S_CLEAR) ? '0 : value;
    coef_wd = bias_wd;
    deg_wd = (state == S_CLEAR) ? '0 : term_degree;
    var_wa = {TERM_W'(index), SLOT_W'(slot)};
  end

  // Read addresses follow the counters. The spin store is read at the queried
  // index on acceptance, by the bias sweep counter, and otherwise at the term
  // variable just read.
  assign bias_ra = (state == S_IDLE) ? SPIN_W'(index) : scnt[SPIN_W-1:0];
  assign coef_ra = tcnt[TERM_W-1:0];
  assign deg_ra = tcnt[TERM_W-1:0];
  assign var_ra = {tcnt[TERM_W-1:0], kcnt[SLOT_W-1:0]};
  assign spin_ra = (state == S_IDLE) ? SPIN_W'(index) :
                   (state == S_BIAS) ? scnt[SPIN_W-1:0] : SPIN_W'(var_rd);

  logic is_field;
  assign is_field = (op == OP_FIELD) || (op == OP_DELTA);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr_cnt <= '0; out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (SPIN_W+1)'(MAX_SPINS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op <= opcode; qidx <= index; tcnt <= '0;
            unique case (opcode)
              OP_ENERGY: begin
                acc <= {{16{offset[31]}}, offset}; scnt <= '0; state <= S_BIAS;
              end
              OP_COUPLING: begin
                acc <= '0; state <= S_TDEG;
              end
              OP_FIELD, OP_DELTA: begin
                if ((SPIN_W+1)'(index) >= eff_spins) begin
                  acc <= '0; status <= 1'b1; out_valid <= 1'b1;
                end else begin
                  state <= S_FSPIN;
                end
              end
              default: ;
            endcase
          end
        end
        S_FSPIN: begin
          // bias_rd holds bias[qidx], spin_rd holds spin[qidx]
          qneg <= spin_rd;
          acc <= {{16{bias_rd[31]}}, bias_rd};
          state <= S_TDEG;
        end
        S_BIAS: begin
          // Issue reads for scnt; consume the data in the next cycle.
          if (scnt != '0) begin
            acc <= sat_add(acc, spin_rd ? -{{16{bias_rd[31]}}, bias_rd}
                                        : {{16{bias_rd[31]}}, bias_rd});
          end
          if (scnt == eff_spins) begin
            state <= S_TDEG;
          end else begin
            scnt <= scnt + 1'b1;
          end
        end
        S_TDEG: begin
          if (tcnt == eff_terms) begin
            state <= S_DONE;
          end else begin
            state <= S_VAR; kcnt <= '0; tneg <= 1'b0; hits <= '0; first <= 1'b1;
          end
        end
        S_VAR: begin
          // deg/coef reads for tcnt valid now on first entry
          if (first) begin
            first <= 1'b0;
            coef_q <= coef_rd;
            if (deg_rd < 3'd2) len <= '0;
            else if (deg_rd > 3'(MAX_DEGREE)) len <= (SLOT_W+1)'(MAX_DEGREE);
            else len <= (SLOT_W+1)'(deg_rd);
            if (deg_rd < 3'd2) begin
              tcnt <= tcnt + 1'b1; state <= S_TDEG;
            end
          end else if (kcnt == len) begin
            state <= S_TACC;
          end else begin
            state <= S_SPIN;
          end
        end
        S_SPIN: begin
          // var_rd is valid; spin read of var_rd issued this cycle
          if (is_field && var_rd == qidx) hits <= hits + 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (spin_rd) tneg <= ~tneg;
          kcnt <= kcnt + 1'b1;
          state <= S_VAR;
        end
        S_TACC: begin
          if (!is_field || hits[0]) begin
            acc <= sat_add(acc, (tneg ^ (is_field && qneg)) ?
                   -{{16{coef_q[31]}}, coef_q} : {{16{coef_q[31]}}, coef_q});
          end
          tcnt <= tcnt + 1'b1;
          state <= S_TDEG;
        end
        S_DONE: begin
          status <= 1'b0;
          // The flip delta is -2 * spin * field, saturated once more.
          if (op == OP_DELTA) begin
            acc <= sat_double(acc, !qneg);
          end
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result_value = acc;
endmodule
`default_nettype wire
